// ===== rtl/acdp_pkg.sv =====
package acdp_pkg;

	typedef struct packed {
		logic [31:0] instruction;
		logic [31:0] first_operand;
		logic [31:0] shifted_operand;
		logic [7:0]  shift_amount_reg;
		logic [3:0]  flags_in;
		logic        user_mode;
	} req_t;

	typedef struct packed {
		logic        cond_passed;
		logic [3:0]  instr_class;
		logic [31:0] alu_result;
		logic        write_dest;
		logic [3:0]  dest_index;
		logic [3:0]  flags_out;
		logic        flags_update;
		logic        restore_psr;
		logic        pc_written;
	} rsp_t;

	typedef enum logic [3:0] {
		CLS_DATAPROC = 4'd0, CLS_MUL = 4'd1, CLS_SWAP = 4'd2, CLS_PSR = 4'd3,
		CLS_LDST = 4'd4, CLS_UNDEF = 4'd5, CLS_BLOCK = 4'd6, CLS_BRANCH = 4'd7,
		CLS_CPDT = 4'd8, CLS_SWI = 4'd9, CLS_COPROC = 4'd10
	} class_t;

	typedef enum logic [3:0] {
		OP_AND = 4'h0, OP_EOR = 4'h1, OP_SUB = 4'h2, OP_RSB = 4'h3,
		OP_ADD = 4'h4, OP_ADC = 4'h5, OP_SBC = 4'h6, OP_RSC = 4'h7,
		OP_TST = 4'h8, OP_TEQ = 4'h9, OP_CMP = 4'hA, OP_CMN = 4'hB,
		OP_ORR = 4'hC, OP_MOV = 4'hD, OP_BIC = 4'hE, OP_MVN = 4'hF
	} op_t;

	localparam logic [1:0] SH_LSL = 2'd0;
	localparam logic [1:0] SH_LSR = 2'd1;
	localparam logic [1:0] SH_ASR = 2'd2;
	localparam logic [1:0] SH_ROR = 2'd3;
	localparam logic [3:0] PC_INDEX = 4'd15;

	localparam logic [15:0] COND_MASKS [16] = '{
		16'hf0f0, 16'h0f0f, 16'hcccc, 16'h3333, 16'hff00, 16'h00ff, 16'haaaa, 16'h5555,
		16'h0c0c, 16'hf3f3, 16'haa55, 16'h55aa, 16'h0a05, 16'hf5fa, 16'hffff, 16'h0000
	};

endpackage

// ===== rtl/acdp_stream_if.sv =====
interface acdp_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/acdp_shifter.sv =====
module acdp_shifter (
	input  logic [31:0] instruction,
	input  logic [31:0] value,
	input  logic [7:0]  amount_reg,
	input  logic        carry_in,
	output logic [31:0] operand,
	output logic        shift_carry
);
	logic [1:0]  kind;
	logic [7:0]  amt;
	logic [3:0]  rot;
	logic [4:0]  rot2;
	logic [63:0] dbl;
	logic [63:0] imm_dbl;
	logic [31:0] sgn;

	// operand 2: rotated immediate or barrel shifted register
	always_comb begin
		kind = instruction[6:5];
		rot = instruction[11:8];
		rot2 = {rot, 1'b0};
		imm_dbl = {24'd0, instruction[7:0], 24'd0, instruction[7:0]} >> rot2;
		sgn = {32{value[31]}};
		operand = value;
		shift_carry = carry_in;
		dbl = '0;
		if (instruction[4]) begin
			amt = amount_reg;
		end else begin
			amt = {3'd0, instruction[11:7]};
			if (amt == 8'd0 && (kind == acdp_pkg::SH_LSR || kind == acdp_pkg::SH_ASR)) begin
				amt = 8'd32;
			end
		end
		if (instruction[25]) begin
			operand = imm_dbl[31:0];
			if (rot != 4'd0) begin
				shift_carry = operand[31];
			end
		end else if (!instruction[4] && kind == acdp_pkg::SH_ROR && amt == 8'd0) begin
			// rotate right extended
			operand = {carry_in, value[31:1]};
			shift_carry = value[0];
		end else if (amt != 8'd0) begin
			case (kind)
				acdp_pkg::SH_LSL: begin
					if (amt < 8'd32) begin
						dbl = {32'd0, value} << amt[4:0];
						operand = dbl[31:0];
						shift_carry = dbl[32];
					end else begin
						operand = '0;
						shift_carry = (amt == 8'd32) ? value[0] : 1'b0;
					end
				end
				acdp_pkg::SH_LSR, acdp_pkg::SH_ASR: begin
					if (amt < 8'd32) begin
						dbl = {(kind == acdp_pkg::SH_ASR) ? sgn : 32'd0, value} >> amt[4:0];
						operand = dbl[31:0];
						shift_carry = value[amt[4:0] - 5'd1];
					end else if (kind == acdp_pkg::SH_ASR) begin
						operand = sgn;
						shift_carry = value[31];
					end else begin
						operand = '0;
						shift_carry = (amt == 8'd32) ? value[31] : 1'b0;
					end
				end
				default: begin
					dbl = {value, value} >> amt[4:0];
					operand = dbl[31:0];
					shift_carry = (amt[4:0] == 5'd0) ? value[31] : value[amt[4:0] - 5'd1];
				end
			endcase
		end
	end
endmodule

// ===== rtl/acdp_alu.sv =====
module acdp_alu (
	input  acdp_pkg::req_t req,
	output acdp_pkg::rsp_t rsp
);
	logic [31:0] w;
	logic [31:0] a;
	logic [31:0] b;
	logic        cin;
	logic        sc;
	logic [3:0]  cls;
	logic        pass;
	logic [3:0]  op;
	logic [31:0] x;
	logic [31:0] y;
	logic        ci;
	logic [32:0] sum;
	logic [31:0] res;
	logic        arith;
	logic        c;
	logic        v;
	logic        wr;
	logic        rest;
	logic        pcw;

	assign w = req.instruction;
	assign a = req.first_operand;
	assign cin = req.flags_in[1];

	acdp_shifter u_shifter (
		.instruction(w), .value(req.shifted_operand), .amount_reg(req.shift_amount_reg),
		.carry_in(cin), .operand(b), .shift_carry(sc)
	);

	// condition and class decode
	always_comb begin
		pass = acdp_pkg::COND_MASKS[w[31:28]][req.flags_in];
		if ((w & 32'h0FC000F0) == 32'h00000090) cls = acdp_pkg::CLS_MUL;
		else if (w[27:26] == 2'b00) begin
			if ((w & 32'h01900000) == 32'h01000000)
				cls = ((w & 32'h02200080) == 32'h00000080) ? acdp_pkg::CLS_SWAP
					: acdp_pkg::CLS_PSR;
			else cls = acdp_pkg::CLS_DATAPROC;
		end
		else if (w[27:25] == 3'b011 && w[4]) cls = acdp_pkg::CLS_UNDEF;
		else if (w[27:26] == 2'b01) cls = acdp_pkg::CLS_LDST;
		else if (w[27:25] == 3'b100) cls = acdp_pkg::CLS_BLOCK;
		else if (w[27:25] == 3'b101) cls = acdp_pkg::CLS_BRANCH;
		else if (w[27:25] == 3'b110) cls = acdp_pkg::CLS_CPDT;
		else if (w[27:24] == 4'hF) cls = acdp_pkg::CLS_SWI;
		else cls = acdp_pkg::CLS_COPROC;
	end

	// adder operand selection and logic ops
	always_comb begin
		op = w[24:21];
		arith = 1'b1;
		x = a;
		y = b;
		ci = 1'b0;
		case (op)
			acdp_pkg::OP_SUB, acdp_pkg::OP_CMP: begin y = ~b; ci = 1'b1; end
			acdp_pkg::OP_RSB: begin x = b; y = ~a; ci = 1'b1; end
			acdp_pkg::OP_ADD, acdp_pkg::OP_CMN: ci = 1'b0;
			acdp_pkg::OP_ADC: ci = cin;
			acdp_pkg::OP_SBC: begin y = ~b; ci = cin; end
			acdp_pkg::OP_RSC: begin x = b; y = ~a; ci = cin; end
			default: arith = 1'b0;
		endcase
		sum = {1'b0, x} + {1'b0, y} + {32'd0, ci};
		case (op)
			acdp_pkg::OP_AND, acdp_pkg::OP_TST: res = a & b;
			acdp_pkg::OP_EOR, acdp_pkg::OP_TEQ: res = a ^ b;
			acdp_pkg::OP_ORR: res = a | b;
			acdp_pkg::OP_MOV: res = b;
			acdp_pkg::OP_BIC: res = a & ~b;
			acdp_pkg::OP_MVN: res = ~b;
			default: res = sum[31:0];
		endcase
		c = arith ? sum[32] : sc;
		v = arith ? ((x[31] ^ sum[31]) & (y[31] ^ sum[31])) : req.flags_in[0];
	end

	// result assembly
	always_comb begin
		wr = !(op inside {acdp_pkg::OP_TST, acdp_pkg::OP_TEQ, acdp_pkg::OP_CMP,
			acdp_pkg::OP_CMN});
		pcw = wr && w[15:12] == acdp_pkg::PC_INDEX;
		rest = w[20] && w[15:12] == acdp_pkg::PC_INDEX && !req.user_mode;
		rsp = '0;
		rsp.cond_passed = pass;
		rsp.instr_class = cls;
		rsp.dest_index = w[15:12];
		rsp.flags_out = req.flags_in;
		if (pass && cls == acdp_pkg::CLS_DATAPROC) begin
			rsp.alu_result = pcw ? {res[31:2], 2'b00} : res;
			rsp.write_dest = wr;
			rsp.pc_written = pcw;
			rsp.restore_psr = rest;
			rsp.flags_update = w[20] && !rest;
			if (w[20] && !rest) begin
				rsp.flags_out = {res[31], res == 32'd0, c, v};
			end
		end
	end
endmodule

// ===== rtl/arm_condition_and_data_processing_alu_unit.sv =====
// channel | dir | payload
// req     | in  | instruction, operands, shift byte, flags, user mode
// rsp     | out | condition, class, result, destination, flags, marks
// an accepted request gives its response in the next cycle from the output register
// a new request is taken each cycle while the output register is empty or being drained
// results come from a single combinational shifter/adder pass, one item per cycle unless the output stalls
// arst_n clears the output valid flag; payload registers are not reset
module arm_condition_and_data_processing_alu_unit (
	input  logic clk,
	input  logic arst_n,
	acdp_stream_if.sink   req,
	acdp_stream_if.source rsp
);
	acdp_pkg::rsp_t res;
	acdp_pkg::rsp_t data_s1;
	logic           valid_s1;

	acdp_alu u_alu (.req(req.data), .rsp(res));

	assign req.ready = !valid_s1 || rsp.ready;
	assign rsp.valid = valid_s1;
	assign rsp.data = data_s1;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			data_s1 <= res;
		end
	end
endmodule

// ===== rtl/acdp_checker.sv =====
module acdp_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input acdp_pkg::rsp_t rsp_data
);
	// response follows each accepted request
	a_resp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid) else $error("response missing");
	// ready whenever the output is free
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready) else $error("stall with empty output");
	// a stalled response holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("stalled response changed");
	// restore and flag update never together
	a_rest: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_data.restore_psr && rsp_data.flags_update))
		else $error("restore with flag update");
	// pc writes are word aligned, write the destination and have passed their condition
	a_pc: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.pc_written |-> rsp_data.alu_result[1:0] == 2'b00 &&
		rsp_data.write_dest && rsp_data.cond_passed) else $error("bad pc write");
endmodule

bind arm_condition_and_data_processing_alu_unit acdp_checker u_checker (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
